FILE: sv/i2c_master_register_access_sequencer_assert.svh
// assertion macros for the i2c register access sequencer
`ifndef I2C_MASTER_REGISTER_ACCESS_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge out of reset
`define I2C_SEQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("i2c sequencer check failed");

// condition that must lead to a consequence in the following cycle
`define I2C_SEQ_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("i2c sequencer sequence check failed");

`else

`define I2C_SEQ_ASSERT(lbl, prop)
`define I2C_SEQ_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

FILE: sv/i2c_seq_pkg.sv
// shared types and constants of the i2c register access sequencer
`default_nettype none

package i2c_seq_pkg;

    localparam int BUFFER_DEPTH_DEF = 256;
    localparam int LOAD_INDEX_W     = 8;
    localparam int LOAD_SPAN        = 2 ** LOAD_INDEX_W;
    localparam int LEN_W            = 9;
    localparam int S_TDATA_W        = 48;
    localparam int S_TUSER_W        = 3;
    localparam int M_TDATA_W        = 40;

    // func codes on s_tuser
    localparam logic [S_TUSER_W-1:0] FUNC_START_READ  = 3'd0;
    localparam logic [S_TUSER_W-1:0] FUNC_START_WRITE = 3'd1;
    localparam logic [S_TUSER_W-1:0] FUNC_STATUS      = 3'd2;
    localparam logic [S_TUSER_W-1:0] FUNC_BUS_ERROR   = 3'd3;
    localparam logic [S_TUSER_W-1:0] FUNC_LOAD_BYTE   = 3'd4;

    // direction bit of the address byte
    localparam logic [7:0] DIR_MASK = 8'hFE;
    localparam logic [7:0] DIR_READ = 8'h01;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_START_RD,
        OP_START_WR,
        OP_STATUS,
        OP_BUS_ERR,
        OP_LOAD
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_R_START,
        PH_R_WADDR,
        PH_R_REG,
        PH_R_RSTART,
        PH_R_RADDR,
        PH_R_DATA,
        PH_W_START,
        PH_W_ADDR,
        PH_W_NEXT,
        PH_W_LAST
    } phase_t;

    typedef struct packed {
        op_t                     op;
        logic [7:0]              device_address;
        logic [7:0]              register_address;
        logic [LEN_W-1:0]        transfer_length;
        logic                    start_sent;
        logic                    address_acked;
        logic                    tx_empty;
        logic                    byte_finished;
        logic                    rx_full;
        logic [7:0]              data_byte;
        logic [LOAD_INDEX_W-1:0] load_index;
    } q_item_t;

    typedef struct packed {
        logic       busy_res;
        logic       done_error;
        logic       done_res;
        logic [7:0] rx_index;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       ack_off;
        logic       ack_on;
        logic       issue_stop;
        logic       issue_start;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/i2c_seq_ram.sv
// generic single write port ram with registered read
`default_nettype none

module i2c_seq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/i2c_seq_front.sv
// front end: accepts items, classifies func and queues them for the back end
`default_nettype none

module i2c_seq_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [i2c_seq_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [i2c_seq_pkg::S_TUSER_W-1:0] s_tuser,
    input  wire logic                             pop,
    output logic                                  q_valid,
    output i2c_seq_pkg::q_item_t                  q_item
);

    import i2c_seq_pkg::*;

    q_item_t    item_in;
    q_item_t    mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    // classify the func code
    always_comb
    begin
        case (s_tuser)
            FUNC_START_READ:  item_in.op = OP_START_RD;
            FUNC_START_WRITE: item_in.op = OP_START_WR;
            FUNC_STATUS:      item_in.op = OP_STATUS;
            FUNC_BUS_ERROR:   item_in.op = OP_BUS_ERR;
            FUNC_LOAD_BYTE:   item_in.op = OP_LOAD;
            default:          item_in.op = OP_NONE;
        endcase
        item_in.device_address   = s_tdata[7:0];
        item_in.register_address = s_tdata[15:8];
        item_in.transfer_length  = s_tdata[24:16];
        item_in.start_sent       = s_tdata[25];
        item_in.address_acked    = s_tdata[26];
        item_in.tx_empty         = s_tdata[27];
        item_in.byte_finished    = s_tdata[28];
        item_in.rx_full          = s_tdata[29];
        item_in.data_byte        = s_tdata[37:30];
        item_in.load_index       = s_tdata[45:38];
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/i2c_seq_back.sv
// back end: phase machine, transmit buffer and output register
`default_nettype none

module i2c_seq_back #(
    parameter int BUFFER_DEPTH = i2c_seq_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             q_valid,
    input  wire i2c_seq_pkg::q_item_t             q_item,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [i2c_seq_pkg::M_TDATA_W-1:0] m_tdata
);

    import i2c_seq_pkg::*;

    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [ADDR_W-1:0] PTR_LAST = ADDR_W'(BUFFER_DEPTH - 1);

    phase_t            phase_reg, phase_next;
    logic [7:0]        dev_reg, dev_next;
    logic [7:0]        regaddr_reg, regaddr_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              m_valid_reg, m_valid_next;
    logic              from_ram_reg;
    res_t              res_reg, res_next;
    logic              from_ram_next;
    logic [LEN_W:0]    pos_inc;
    logic              fire;
    logic              ram_wr_en, ram_rd_en;
    logic [7:0]        ram_rd_data;
    logic [7:0]        tx_byte_out;
    logic [ADDR_W-1:0] load_mod [LOAD_SPAN];

    // load index folded onto the buffer depth
    for (genvar g = 0; g < LOAD_SPAN; g++)
    begin : g_load_mod
        assign load_mod[g] = ADDR_W'(g % BUFFER_DEPTH);
    end

    i2c_seq_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_tx_buffer (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (load_mod[q_item.load_index]),
        .wr_data (q_item.data_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (ptr_reg),
        .rd_data (ram_rd_data)
    );

    assign fire    = q_valid && (!m_valid_reg || m_tready);
    assign pop     = fire;
    assign pos_inc = {1'b0, pos_reg} + (LEN_W+1)'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        dev_next      = dev_reg;
        regaddr_next  = regaddr_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        ptr_next      = ptr_reg;
        res_next      = '0;
        from_ram_next = 1'b0;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;

        if (fire)
        begin
            case (q_item.op)
                OP_START_RD, OP_START_WR:
                begin
                    dev_next             = q_item.device_address;
                    regaddr_next         = q_item.register_address;
                    len_next             = q_item.transfer_length;
                    pos_next             = '0;
                    ptr_next             = '0;
                    res_next.issue_start = 1'b1;
                    if (q_item.op == OP_START_RD)
                    begin
                        res_next.ack_on = 1'b1;
                        phase_next      = PH_R_START;
                    end
                    else
                    begin
                        phase_next = PH_W_START;
                    end
                end
                OP_BUS_ERR:
                begin
                    res_next.issue_stop = 1'b1;
                    res_next.done_res   = 1'b1;
                    res_next.done_error = 1'b1;
                    phase_next          = PH_IDLE;
                end
                OP_LOAD:
                begin
                    ram_wr_en = 1'b1;
                end
                OP_STATUS:
                begin
                    case (phase_reg)
                        PH_R_START, PH_W_START:
                        begin
                            if (q_item.start_sent)
                            begin
                                res_next.tx_valid = 1'b1;
                                res_next.tx_byte  = dev_reg & DIR_MASK;
                                phase_next = (phase_reg == PH_R_START) ? PH_R_WADDR : PH_W_ADDR;
                            end
                        end
                        PH_R_WADDR, PH_W_ADDR:
                        begin
                            if (q_item.address_acked)
                            begin
                                res_next.tx_valid = 1'b1;
                                res_next.tx_byte  = regaddr_reg;
                                phase_next = (phase_reg == PH_R_WADDR) ? PH_R_REG : PH_W_NEXT;
                            end
                        end
                        PH_R_REG:
                        begin
                            if (q_item.tx_empty)
                            begin
                                res_next.issue_start = 1'b1;
                                phase_next           = PH_R_RSTART;
                            end
                        end
                        PH_R_RSTART:
                        begin
                            if (q_item.start_sent)
                            begin
                                res_next.tx_valid = 1'b1;
                                res_next.tx_byte  = dev_reg | DIR_READ;
                                phase_next        = PH_R_RADDR;
                            end
                        end
                        PH_R_RADDR:
                        begin
                            if (q_item.address_acked)
                            begin
                                phase_next = PH_R_DATA;
                            end
                        end
                        PH_R_DATA:
                        begin
                            if (q_item.rx_full)
                            begin
                                res_next.rx_valid = 1'b1;
                                res_next.rx_byte  = q_item.data_byte;
                                res_next.rx_index = pos_reg[7:0];
                                // last byte, or a zero length read
                                if (pos_inc >= {1'b0, len_reg})
                                begin
                                    res_next.ack_off    = 1'b1;
                                    res_next.issue_stop = 1'b1;
                                    res_next.done_res   = 1'b1;
                                    phase_next          = PH_IDLE;
                                end
                                pos_next = pos_inc[LEN_W-1:0];
                            end
                        end
                        PH_W_NEXT:
                        begin
                            if (q_item.tx_empty)
                            begin
                                if (pos_reg < len_reg)
                                begin
                                    res_next.tx_valid = 1'b1;
                                    ram_rd_en         = 1'b1;
                                    from_ram_next     = 1'b1;
                                    pos_next          = pos_inc[LEN_W-1:0];
                                    ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_W_LAST;
                                end
                            end
                        end
                        PH_W_LAST:
                        begin
                            if (q_item.byte_finished)
                            begin
                                res_next.issue_stop = 1'b1;
                                res_next.done_res   = 1'b1;
                                phase_next          = PH_IDLE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
        res_next.busy_res = (phase_next != PH_IDLE);

        if (fire)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            dev_reg      <= '0;
            regaddr_reg  <= '0;
            len_reg      <= '0;
            pos_reg      <= '0;
            ptr_reg      <= '0;
            m_valid_reg  <= 1'b0;
            from_ram_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            dev_reg     <= dev_next;
            regaddr_reg <= regaddr_next;
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
            if (fire)
            begin
                from_ram_reg <= from_ram_next;
            end
        end
    end

    // buffer data comes straight from the ram output register
    assign tx_byte_out = from_ram_reg ? ram_rd_data : res_reg.tx_byte;
    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = {7'd0, res_reg.busy_res, res_reg.done_error, res_reg.done_res,
                          res_reg.rx_index, res_reg.rx_byte, res_reg.rx_valid,
                          tx_byte_out, res_reg.tx_valid, res_reg.ack_off, res_reg.ack_on,
                          res_reg.issue_stop, res_reg.issue_start};

endmodule

`default_nettype wire

FILE: sv/i2c_master_register_access_sequencer.sv
// top level of the i2c master register access sequencer
//
//  channel  | direction | contents
//  ---------+-----------+------------------------------------------------
//  s_axis   | in        | one command or status event per transfer
//  m_axis   | out       | one bus request / result per input transfer
//
// one item per clock sustained while m_tready stays high; an item taken in passes
// the front queue register, then the result register of the phase machine stage
// the rate is set by the phase update in the back end
// rst_n clears the phase machine, saved transfer state, the front queue and the
// output valid flag; the transmit buffer holds nothing defined until loaded
// a stalled m_axis fills the two-entry queue, then s_tready drops
`default_nettype none

`include "i2c_master_register_access_sequencer_assert.svh"

module i2c_master_register_access_sequencer #(
    parameter int BUFFER_DEPTH = i2c_seq_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // device_address[7:0], register_address[15:8], transfer_length[24:16],
    // start_sent[25], address_acked[26], tx_empty[27], byte_finished[28],
    // rx_full[29], data_byte[37:30], load_index[45:38], zero pad above
    input  wire logic [i2c_seq_pkg::S_TDATA_W-1:0] s_tdata,
    // func[2:0]
    input  wire logic [i2c_seq_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // issue_start[0], issue_stop[1], ack_on[2], ack_off[3], tx_valid[4],
    // tx_byte[12:5], rx_valid[13], rx_byte[21:14], rx_index[29:22],
    // done_res[30], done_error[31], busy_res[32], zero pad above
    output logic      [i2c_seq_pkg::M_TDATA_W-1:0] m_tdata
);

    import i2c_seq_pkg::*;

    logic    q_valid;
    logic    pop;
    q_item_t q_item;

    // front: decode func and buffer up to two items
    i2c_seq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    // back: phase machine, tx buffer ram and result register
    i2c_seq_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // with the result register empty the back end drains, so the queue has room
    `I2C_SEQ_ASSERT(a_ready_when_out_empty, !m_tvalid |-> s_tready)
    // error completions only ever come with done
    `I2C_SEQ_ASSERT(a_err_needs_done, m_tvalid |-> (!m_tdata[31] || m_tdata[30]))
    // a finished transfer leaves the sequencer idle
    `I2C_SEQ_ASSERT(a_done_not_busy, (m_tvalid && m_tdata[30]) |-> !m_tdata[32])
    // buffer data only shows on the port when a byte is sent
    `I2C_SEQ_ASSERT(a_tx_byte_zero, (m_tvalid && !m_tdata[4]) |-> (m_tdata[12:5] == 8'd0))
    // an item accepted while m_tvalid is low is followed by a valid result on m_axis
    `I2C_SEQ_ASSERT_NEXT(a_item_reaches_out, (s_tvalid && s_tready && !m_tvalid), ##1 m_tvalid)

endmodule

`default_nettype wire
